>>> rtl/cvot_pkg.sv
// ----------------------------------------------------------------------------
// cvot_pkg
// Shared widths, register indexes, fault codes and reset values of the
// current vector overcurrent trip block.
// ----------------------------------------------------------------------------
package cvot_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned MagW          = 17;
  localparam int unsigned MagOutW       = 16;
  localparam int unsigned DeltaW        = 17;
  localparam int unsigned LimitW        = 16;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned FaultW        = 2;

  localparam logic [LimitW-1:0] PanicLimitRst    = 16'hFFFF;
  localparam logic [LimitW-1:0] OverloadLevelRst = 16'hFFFF;
  localparam logic [TimeW-1:0]  TripTimeRst      = 32'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPanicLimit    = 2'd0,
    CfgOverloadLevel = 2'd1,
    CfgTripTime      = 2'd2
  } cfg_idx_e;

  typedef enum logic [FaultW-1:0] {
    FaultNone     = 2'd0,
    FaultPanic    = 2'd1,
    FaultOverload = 2'd2
  } fault_e;

endpackage

>>> rtl/cvot_in_if.sv
// ----------------------------------------------------------------------------
// cvot_in_if
// Sample channel: two current components and a microsecond timestamp.
// ----------------------------------------------------------------------------
interface cvot_in_if #(
  parameter int unsigned SampleBits = cvot_pkg::SampleBitsDef
);
  import cvot_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] current_cross;
  logic [SampleBits-1:0] current_lateral;
  logic [TimeW-1:0]      time_now_us;

  modport source (
    output valid, current_cross, current_lateral, time_now_us,
    input  ready
  );

  modport sink (
    input  valid, current_cross, current_lateral, time_now_us,
    output ready
  );
endinterface

>>> rtl/cvot_out_if.sv
// ----------------------------------------------------------------------------
// cvot_out_if
// Result channel: magnitude, magnitude change and fault code.
// ----------------------------------------------------------------------------
interface cvot_out_if;
  import cvot_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MagOutW-1:0]       magnitude_out;
  logic signed [DeltaW-1:0] magnitude_change;
  logic [FaultW-1:0]        fault_code;

  modport source (
    output valid, magnitude_out, magnitude_change, fault_code,
    input  ready
  );

  modport sink (
    input  valid, magnitude_out, magnitude_change, fault_code,
    output ready
  );
endinterface

>>> rtl/current_vector_overcurrent_trip_top.sv
// ----------------------------------------------------------------------------
// current_vector_overcurrent_trip_top
// Overcurrent trip on a two-axis current vector.
// ----------------------------------------------------------------------------
// One word is taken at a time. The sum of squares is built by a bit-serial
// shift-add, then the floor square root comes out of a restoring root unit at
// one bit per cycle, and the StDone state applies the panic and overload
// checks and loads the output register. The result side takes words as they
// come; a result waiting in the output register holds the next one in StDone
// only. Configuration writes take effect on the next clock edge.
// ----------------------------------------------------------------------------
module current_vector_overcurrent_trip_top #(
  parameter int unsigned SAMPLE_BITS = cvot_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cvot_in_if.sink                       in_i,
  cvot_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [cvot_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cvot_pkg::CfgDataW-1:0] cfg_data_i
);
  import cvot_pkg::*;

  localparam int unsigned SumW  = 2 * SAMPLE_BITS;
  localparam int unsigned RootW = SAMPLE_BITS;
  localparam int unsigned RemW  = RootW + 3;
  localparam int unsigned CntW  = $clog2(SAMPLE_BITS + 1);
  localparam int unsigned ExtW  = (RootW > MagW) ? RootW : MagW;
  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StRoot = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [LimitW-1:0] panic_limit_q, overload_level_q;
  logic [TimeW-1:0]  trip_time_q;
  logic [MagW-1:0]   last_mag_q;
  logic [TimeW-1:0]  stamp_q;
  logic [TimeW-1:0]  now_q;

  logic [SumW-1:0]        acc_q, acc_d;
  logic [SumW-1:0]        xm_q, xm_d, ym_q, ym_d;
  logic [SAMPLE_BITS-1:0] xb_q, xb_d, yb_q, yb_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [RootW-1:0]       root_q, root_d;

  logic                     out_valid_q;
  logic [MagOutW-1:0]       out_mag_q;
  logic signed [DeltaW-1:0] out_delta_q;
  logic [FaultW-1:0]        out_fault_q;

  logic [SAMPLE_BITS-1:0] abs_x, abs_y;
  logic [RemW-1:0]        rem_sh, trial;
  logic [ExtW-1:0]        root_ext;
  logic [MagW-1:0]        mag;
  logic signed [MagW:0]   delta;
  logic signed [MagW+1:0] mag_plus;
  logic [TimeW-1:0]       elapsed;
  logic                   in_take, out_free, load_out;
  fault_e                 fault;
  logic [DeltaW-1:0]      delta_sat;

  assign in_take  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign load_out = (state_q == StDone) && out_free;

  assign in_i.ready = (state_q == StIdle);

  assign abs_x = in_i.current_cross[SAMPLE_BITS-1]
               ? SAMPLE_BITS'(-in_i.current_cross) : in_i.current_cross;
  assign abs_y = in_i.current_lateral[SAMPLE_BITS-1]
               ? SAMPLE_BITS'(-in_i.current_lateral) : in_i.current_lateral;

  assign rem_sh = {rem_q[RemW-3:0], acc_q[SumW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    xm_d    = xm_q;
    ym_d    = ym_q;
    xb_d    = xb_q;
    yb_d    = yb_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          acc_d   = '0;
          xm_d    = SumW'(abs_x);
          ym_d    = SumW'(abs_y);
          xb_d    = abs_x;
          yb_d    = abs_y;
          cnt_d   = CntW'(SAMPLE_BITS - 1);
          state_d = StMul;
        end
      end
      StMul: begin
        acc_d = acc_q + (xb_q[0] ? xm_q : '0) + (yb_q[0] ? ym_q : '0);
        xm_d  = xm_q << 1;
        ym_d  = ym_q << 1;
        xb_d  = xb_q >> 1;
        yb_d  = yb_q >> 1;
        if (cnt_q == '0) begin
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CntW'(RootW - 1);
          state_d = StRoot;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StRoot: begin
        acc_d = acc_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign root_ext = ExtW'(root_q);
  assign mag      = (root_ext > ExtW'(MagMax)) ? MagMax : root_ext[MagW-1:0];
  assign delta    = $signed({1'b0, mag}) - $signed({1'b0, last_mag_q});
  assign mag_plus = $signed({2'b00, mag}) + (MagW+2)'(delta);
  assign elapsed  = now_q - stamp_q;

  always_comb begin
    priority if (mag > MagW'(panic_limit_q) ||
                 mag_plus > $signed({3'b000, panic_limit_q})) begin
      fault = FaultPanic;
    end else if (mag > MagW'(overload_level_q) && elapsed > trip_time_q) begin
      fault = FaultOverload;
    end else begin
      fault = FaultNone;
    end
  end

  always_comb begin
    priority if (delta > $signed((MagW+1)'(65535))) begin
      delta_sat = 17'h0FFFF;
    end else if (delta < -$signed((MagW+1)'(65536))) begin
      delta_sat = 17'h10000;
    end else begin
      delta_sat = delta[DeltaW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      cnt_q            <= '0;
      out_valid_q      <= 1'b0;
      panic_limit_q    <= PanicLimitRst;
      overload_level_q <= OverloadLevelRst;
      trip_time_q      <= TripTimeRst;
      last_mag_q       <= '0;
      stamp_q          <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPanicLimit:    panic_limit_q    <= cfg_data_i[LimitW-1:0];
          CfgOverloadLevel: overload_level_q <= cfg_data_i[LimitW-1:0];
          CfgTripTime:      trip_time_q      <= cfg_data_i[TimeW-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        last_mag_q  <= mag;
        if (fault == FaultOverload) begin
          stamp_q <= '0;
        end else if (fault == FaultNone && !(mag > MagW'(overload_level_q))) begin
          stamp_q <= now_q;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    xm_q   <= xm_d;
    ym_q   <= ym_d;
    xb_q   <= xb_d;
    yb_q   <= yb_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (in_take) begin
      now_q <= in_i.time_now_us;
    end
    if (load_out) begin
      out_mag_q   <= mag[MagW-1] ? {MagOutW{1'b1}} : mag[MagOutW-1:0];
      out_delta_q <= $signed(delta_sat);
      out_fault_q <= fault;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.magnitude_out    = out_mag_q;
  assign out_o.magnitude_change = out_delta_q;
  assign out_o.fault_code       = out_fault_q;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the current vector overcurrent trip block. A table
// of directed words hits the sample extremes, the panic, overload and timer
// wrap cases and every register, then random phases reprogram the limits and
// send runs of steady samples at one scale mixed with noise. Every result
// word is checked field by field against its table row or an in-bench model of the trip logic.
// ----------------------------------------------------------------------------
module testbench;
  import cvot_pkg::*;

  localparam int unsigned SampleW      = SampleBitsDef;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned Phases       = 12;
  localparam int unsigned PhaseWords   = 50;
  localparam int unsigned MaxPrints    = 50;
  localparam longint      MagSat       = (longint'(1) << MagW) - 1;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 2'd3;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    logic [MagOutW-1:0]       mag;
    logic signed [DeltaW-1:0] chg;
    fault_e                   fault;
  } trip_word_t;

  typedef enum logic {RowWord, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    sample_t             cur_x;
    sample_t             cur_y;
    logic [TimeW-1:0]    at_us;
    trip_word_t          want;
  } stim_row_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cvot_in_if #(.SampleBits(SampleW)) in_if ();
  cvot_out_if out_if ();

  current_vector_overcurrent_trip_top #(
    .SAMPLE_BITS(SampleW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // trip model state and limits
  logic [LimitW-1:0] lim_panic     = PanicLimitRst;
  logic [LimitW-1:0] lim_level     = OverloadLevelRst;
  logic [TimeW-1:0]  lim_trip      = TripTimeRst;
  logic [MagW-1:0]   prev_mag      = '0;
  logic [TimeW-1:0]  calm_stamp_us = '0;

  trip_word_t       awaited_trip_q[$];
  int unsigned      mismatch_cnt   = 0;
  int unsigned      samples_sent   = 0;
  int unsigned      reg_writes     = 0;
  int unsigned      panic_words    = 0;
  int unsigned      overload_words = 0;
  bit               word_offered   = 1'b0;
  bit               send_steady    = 1'b0;
  logic [TimeW-1:0] stamp_us       = '0;

  function automatic trip_word_t compute_trip_word(sample_t cur_x, sample_t cur_y,
                                                   logic [TimeW-1:0] at_us);
    longint           sx;
    longint           sy;
    longint           energy;
    longint           root;
    longint           cand;
    longint           mag;
    longint           chg;
    logic [TimeW-1:0] elapsed;
    int               b;
    trip_word_t       w;
    sx = longint'($signed(cur_x));
    sy = longint'($signed(cur_y));
    if (sx < 0) sx = -sx;
    if (sy < 0) sy = -sy;
    energy = sx * sx + sy * sy;
    root = 0;
    for (b = 24; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= energy) root = cand;
    end
    mag = (root > MagSat) ? MagSat : root;
    chg = mag - longint'(prev_mag);
    prev_mag = mag[MagW-1:0];
    w.fault = FaultNone;
    if (mag > longint'(lim_panic) || mag + chg > longint'(lim_panic)) begin
      w.fault = FaultPanic;
    end else if (mag > longint'(lim_level)) begin
      elapsed = at_us - calm_stamp_us;
      if (elapsed > lim_trip) begin
        w.fault = FaultOverload;
        calm_stamp_us = '0;
      end
    end else begin
      calm_stamp_us = at_us;
    end
    if (chg > 65535) chg = 65535;
    if (chg < -65536) chg = -65536;
    w.mag = (mag > 65535) ? 16'hFFFF : mag[MagOutW-1:0];
    w.chg = chg[DeltaW-1:0];
    return w;
  endfunction

  function automatic stim_row_t word_row(int x, int y, logic [TimeW-1:0] at_us,
                                         int mag, int chg, fault_e fault);
    stim_row_t r;
    r.kind       = RowWord;
    r.reg_idx    = '0;
    r.reg_val    = '0;
    r.cur_x      = sample_t'(x);
    r.cur_y      = sample_t'(y);
    r.at_us      = at_us;
    r.want.mag   = MagOutW'(mag);
    r.want.chg   = DeltaW'(chg);
    r.want.fault = fault;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    stim_row_t r;
    r.kind    = RowWrite;
    r.reg_idx = idx;
    r.reg_val = val;
    r.cur_x   = '0;
    r.cur_y   = '0;
    r.at_us   = '0;
    r.want    = '0;
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrints) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic take_trip_word(logic [MagOutW-1:0] mag, logic signed [DeltaW-1:0] chg,
                                logic [FaultW-1:0] fault);
    trip_word_t want;
    if (awaited_trip_q.size() == 0) begin
      flag_mismatch("word with nothing awaited", mag, 0);
      return;
    end
    want = awaited_trip_q.pop_front();
    if (mag !== want.mag) flag_mismatch("magnitude_out", mag, want.mag);
    if (chg !== want.chg) flag_mismatch("magnitude_change", chg, want.chg);
    if (fault !== want.fault) flag_mismatch("fault_code", fault, want.fault);
    if (want.fault == FaultPanic) panic_words++;
    if (want.fault == FaultOverload) overload_words++;
  endtask

  task automatic offer_sample(sample_t cur_x, sample_t cur_y, logic [TimeW-1:0] at_us,
                              bit typed, trip_word_t want);
    int unsigned gap;
    trip_word_t  model_word;
    if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      if (word_offered) begin
        in_if.valid <= 1'b0;
        word_offered = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_if.current_cross   <= cur_x;
    in_if.current_lateral <= cur_y;
    in_if.time_now_us     <= at_us;
    if (!word_offered) begin
      in_if.valid <= 1'b1;
      word_offered = 1'b1;
    end
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    model_word = compute_trip_word(cur_x, cur_y, at_us);
    awaited_trip_q.push_back(typed ? want : model_word);
    samples_sent++;
  endtask

  task automatic wait_for_results();
    if (word_offered) begin
      in_if.valid <= 1'b0;
      word_offered = 1'b0;
    end
    do @(posedge clk_i); while (awaited_trip_q.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPanicLimit:    lim_panic = val[LimitW-1:0];
      CfgOverloadLevel: lim_level = val[LimitW-1:0];
      CfgTripTime:      lim_trip  = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_limits();
    logic [LimitW-1:0] lvl;
    logic [LimitW-1:0] pnc;
    logic [TimeW-1:0]  trip;
    int unsigned       sum;
    case ($urandom_range(0, 5))
      0:       lvl = '0;
      1:       lvl = 16'hFFFF;
      default: lvl = LimitW'($urandom_range(0, (1 << $urandom_range(1, 16)) - 1));
    endcase
    case ($urandom_range(0, 5))
      0:       pnc = '0;
      1:       pnc = 16'hFFFF;
      default: begin
        sum = lvl + $urandom_range(0, lvl + 8);
        pnc = (sum > 65535) ? 16'hFFFF : sum[LimitW-1:0];
      end
    endcase
    case ($urandom_range(0, 5))
      0:       trip = '0;
      1:       trip = 32'hFFFF_FFFF;
      2:       trip = $urandom;
      default: trip = $urandom_range(0, 1500);
    endcase
    write_reg(CfgOverloadLevel, {16'($urandom), lvl});
    write_reg(CfgPanicLimit, {16'($urandom), pnc});
    write_reg(CfgTripTime, trip);
    if ($urandom_range(0, 2) == 0) write_reg(CfgSpareIdx, $urandom);
  endtask

  task automatic run_phase(int unsigned words);
    int unsigned left;
    int unsigned run_len;
    int unsigned scale;
    bit          noisy;
    sample_t     rx;
    sample_t     ry;
    left = words;
    if ($urandom_range(0, 3) == 0) stamp_us = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    while (left != 0) begin
      run_len = $urandom_range(1, 16);
      if (run_len > left) run_len = left;
      noisy = ($urandom_range(0, 4) == 0);
      scale = $urandom_range(0, SampleW - 1);
      repeat (run_len) begin
        rx = sample_t'($urandom);
        ry = sample_t'($urandom);
        if (noisy) begin
          stamp_us = $urandom;
        end else begin
          rx = $signed(rx) >>> (SampleW - 1 - scale);
          ry = $signed(ry) >>> (SampleW - 1 - scale);
          stamp_us += $urandom_range(0, 200);
        end
        offer_sample(rx, ry, stamp_us, 1'b0, '0);
        left--;
      end
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
  endtask

  initial begin : result_side
    bit          taking;
    bit          take_steady;
    int unsigned stall;
    taking      = 1'b0;
    take_steady = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) take_steady = !take_steady;
      stall = take_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        if (taking) begin
          out_if.ready <= 1'b0;
          taking = 1'b0;
        end
        repeat (stall) @(posedge clk_i);
      end
      if (!taking) begin
        out_if.ready <= 1'b1;
        taking = 1'b1;
      end
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      take_trip_word(out_if.magnitude_out, out_if.magnitude_change, out_if.fault_code);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[%0t] no handshake for %0d cycles", $time, StallLimit);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_rows[$];
    int unsigned phase;
    in_if.valid           <= 1'b0;
    in_if.current_cross   <= '0;
    in_if.current_lateral <= '0;
    in_if.time_now_us     <= '0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= '0;
    cfg_data_i            <= '0;

    // reset limits: only a doubled jump in magnitude can panic
    dir_rows.push_back(word_row(0, 0, 32'd0, 0, 0, FaultNone));
    dir_rows.push_back(word_row(-32768, -32768, 32'd5, 46340, 46340, FaultPanic));
    dir_rows.push_back(word_row(32767, 32767, 32'd10, 46339, -1, FaultNone));
    dir_rows.push_back(word_row(0, 0, 32'd15, 0, -46339, FaultNone));
    dir_rows.push_back(word_row(-32768, 0, 32'd20, 32768, 32768, FaultPanic));
    dir_rows.push_back(word_row(0, 32767, 32'd25, 32767, -1, FaultNone));
    dir_rows.push_back(word_row(3, 4, 32'd30, 5, -32762, FaultNone));
    dir_rows.push_back(word_row(-3, -4, 32'd35, 5, 0, FaultNone));
    dir_rows.push_back(word_row(1, 1, 32'd40, 1, -4, FaultNone));
    // zero trip time: overload on the first tick above the level
    dir_rows.push_back(write_row(CfgPanicLimit, 32'd100));
    dir_rows.push_back(write_row(CfgOverloadLevel, 32'd50));
    dir_rows.push_back(write_row(CfgTripTime, 32'd0));
    dir_rows.push_back(word_row(30, 40, 32'd100, 50, 49, FaultNone));
    dir_rows.push_back(word_row(36, 48, 32'd100, 60, 10, FaultNone));
    dir_rows.push_back(word_row(36, 48, 32'd101, 60, 0, FaultOverload));
    dir_rows.push_back(word_row(36, 48, 32'd101, 60, 0, FaultOverload));
    dir_rows.push_back(word_row(60, 80, 32'd102, 100, 40, FaultPanic));
    // timer wrap at the largest trip times; spare index must not land
    dir_rows.push_back(write_row(CfgTripTime, 32'hFFFF_FFFF));
    dir_rows.push_back(write_row(CfgSpareIdx, 32'd0));
    dir_rows.push_back(write_row(CfgOverloadLevel, 32'd0));
    dir_rows.push_back(word_row(0, 0, 32'd200, 0, -100, FaultNone));
    dir_rows.push_back(word_row(0, 1, 32'd199, 1, 1, FaultNone));
    dir_rows.push_back(write_row(CfgTripTime, 32'hFFFF_FFFE));
    dir_rows.push_back(word_row(0, -1, 32'd199, 1, 0, FaultOverload));
    dir_rows.push_back(write_row(CfgPanicLimit, 32'd0));
    dir_rows.push_back(word_row(0, 0, 32'd0, 0, -1, FaultNone));
    dir_rows.push_back(word_row(-1, 0, 32'd0, 1, 1, FaultPanic));
    dir_rows.push_back(write_row(CfgPanicLimit, 32'hFFFF_FFFF));
    dir_rows.push_back(write_row(CfgOverloadLevel, 32'h0000_FFFF));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowWrite) begin
        wait_for_results();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        offer_sample(dir_rows[i].cur_x, dir_rows[i].cur_y, dir_rows[i].at_us, 1'b1,
                     dir_rows[i].want);
      end
    end

    for (phase = 0; phase < Phases; phase++) begin
      wait_for_results();
      program_limits();
      run_phase(PhaseWords);
    end

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (awaited_trip_q.size() != 0) begin
      flag_mismatch("results still awaited", awaited_trip_q.size(), 0);
    end
    $display("run: %0d samples across %0d limit settings, %0d register writes",
             samples_sent, Phases + 4, reg_writes);
    $display("run: %0d panic and %0d sustained overload words, %0d mismatches",
             panic_words, overload_words, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
